// ===== hdl/sparse_polynomial_adder_defines.svh =====
// assertion macros for the sparse polynomial adder
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define SPA_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("spa assertion failed");
// checked on every edge, also during reset
`define SPA_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("spa assertion failed");
`else
`define SPA_ASSERT(name, prop)
`define SPA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== hdl/spa_pkg.sv =====
package spa_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ORDER    = 2'd1,
		STATUS_CAPACITY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [15:0] coef;
		logic        [15:0] expo;
	} term_t;

	typedef struct packed {
		logic    op;
		logic    wr;
		logic    close;
		status_t status;
		term_t   term;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PRIME,
		ST_MERGE,
		ST_FINISH,
		ST_ERROR
	} back_state_t;

	// power of two
	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hdl/spa_front.sv =====
module spa_front
	import spa_pkg::*;
#(
	parameter int MAX_TERMS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] coefficient,
	input  logic        [15:0] exponent,
	input  logic               last_term,
	input  logic               q_full,
	output logic               push,
	output cmd_t               cmd
);

	localparam int CW = $clog2(MAX_TERMS + 1);

	logic [CW-1:0] cnt_a_q, cnt_b_q, my_cnt;
	logic [15:0]   exp_a_q, exp_b_q, my_exp;
	logic          ended_a_q, ended_b_q, my_end, other_end;
	logic          ord_err_q, cap_err_q;
	logic          accept, cap, ord, close;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		my_cnt    = func ? cnt_b_q : cnt_a_q;
		my_exp    = func ? exp_b_q : exp_a_q;
		my_end    = func ? ended_b_q : ended_a_q;
		other_end = func ? ended_a_q : ended_b_q;
		cap       = my_cnt == CW'(MAX_TERMS);
		ord       = !cap && (my_cnt != '0) && (exponent <= my_exp);
		close     = !my_end && last_term && other_end;
		push      = accept && !my_end && (!cap || close);
		cmd.op    = func;
		cmd.wr    = !cap;
		cmd.close = close;
		if (ord_err_q || ord) begin
			cmd.status = STATUS_ORDER;
		end else if (cap_err_q || cap) begin
			cmd.status = STATUS_CAPACITY;
		end else begin
			cmd.status = STATUS_OK;
		end
		cmd.term.coef = coefficient;
		cmd.term.expo = exponent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			exp_a_q   <= '0;
			exp_b_q   <= '0;
			ended_a_q <= 1'b0;
			ended_b_q <= 1'b0;
			ord_err_q <= 1'b0;
			cap_err_q <= 1'b0;
		end else if (accept && !my_end) begin
			if (close) begin
				cnt_a_q   <= '0;
				cnt_b_q   <= '0;
				ended_a_q <= 1'b0;
				ended_b_q <= 1'b0;
				ord_err_q <= 1'b0;
				cap_err_q <= 1'b0;
			end else begin
				if (ord) begin
					ord_err_q <= 1'b1;
				end
				if (cap) begin
					cap_err_q <= 1'b1;
				end
				if (func) begin
					if (!cap) begin
						cnt_b_q <= cnt_b_q + CW'(1);
						exp_b_q <= exponent;
					end
					if (last_term) begin
						ended_b_q <= 1'b1;
					end
				end else begin
					if (!cap) begin
						cnt_a_q <= cnt_a_q + CW'(1);
						exp_a_q <= exponent;
					end
					if (last_term) begin
						ended_a_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/spa_queue.sv =====
module spa_queue
	import spa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop_ready
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          pop;

	assign full      = fill_q == NW'(QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

// ===== hdl/spa_back.sv =====
module spa_back
	import spa_pkg::*;
#(
	parameter int MAX_TERMS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [16:0] sum_coefficient,
	output logic        [15:0] sum_exponent,
	output logic               last_result
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	term_t mem_a [MAX_TERMS];
	term_t mem_b [MAX_TERMS];
	term_t rd_a_q, rd_b_q;

	back_state_t        state_q, state_d;
	logic [CW-1:0]      cnt_a_q, cnt_b_q, i_q, j_q, i_d, j_d;
	logic               a_ok, b_ok, adv_a, adv_b;
	logic               step, fin, err, out_free, load, out_set;
	logic signed [16:0] step_c;
	logic [15:0]        step_e;

	logic               pend_v_q;
	logic signed [16:0] pend_c_q;
	logic [15:0]        pend_e_q;

	logic               out_valid_q, out_last_q;
	status_t            out_status_q;
	logic signed [16:0] out_c_q;
	logic [15:0]        out_e_q;

	// error kind of the closing command
	logic               err_order_q;

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign sum_coefficient = out_c_q;
	assign sum_exponent    = out_e_q;
	assign last_result     = out_last_q;
	assign out_free        = !out_valid_q || out_ready;
	assign load            = cmd_valid && cmd_ready && cmd.wr;
	assign out_set         = (step && step_c != '0 && pend_v_q) || fin || err;

	// one merge step: pick the lower exponent, add on a tie
	always_comb begin
		a_ok = i_q < cnt_a_q;
		b_ok = j_q < cnt_b_q;
		if (a_ok && (!b_ok || rd_a_q.expo < rd_b_q.expo)) begin
			adv_a  = 1'b1;
			adv_b  = 1'b0;
			step_c = 17'(rd_a_q.coef);
			step_e = rd_a_q.expo;
		end else if (b_ok && (!a_ok || rd_b_q.expo < rd_a_q.expo)) begin
			adv_a  = 1'b0;
			adv_b  = 1'b1;
			step_c = 17'(rd_b_q.coef);
			step_e = rd_b_q.expo;
		end else begin
			adv_a  = 1'b1;
			adv_b  = 1'b1;
			step_c = 17'(rd_a_q.coef) + 17'(rd_b_q.coef);
			step_e = rd_a_q.expo;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		step      = 1'b0;
		fin       = 1'b0;
		err       = 1'b0;
		i_d       = i_q;
		j_d       = j_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.close) begin
					state_d = (cmd.status != STATUS_OK) ? ST_ERROR : ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (!a_ok && !b_ok) begin
					state_d = ST_FINISH;
				end else if (out_free) begin
					step = 1'b1;
					i_d  = i_q + CW'(adv_a);
					j_d  = j_q + CW'(adv_b);
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					fin     = 1'b1;
					i_d     = '0;
					j_d     = '0;
					state_d = ST_LOAD;
				end
			end
			ST_ERROR: begin
				if (out_free) begin
					err     = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// term stores, read data registered
	always_ff @(posedge clk) begin
		if (load && !cmd.op) begin
			mem_a[cnt_a_q[IW-1:0]] <= cmd.term;
		end
		if (load && cmd.op) begin
			mem_b[cnt_b_q[IW-1:0]] <= cmd.term;
		end
		rd_a_q <= mem_a[i_d[IW-1:0]];
		rd_b_q <= mem_b[j_d[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (load && !cmd.op) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (load && cmd.op) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// a nonzero term waits in pend until the next one shows whether it is final
			if (step && step_c != '0) begin
				pend_v_q <= 1'b1;
			end
			if (fin) begin
				pend_v_q <= 1'b0;
				cnt_a_q  <= '0;
				cnt_b_q  <= '0;
			end
			if (err) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && step_c != '0) begin
			pend_c_q <= step_c;
			pend_e_q <= step_e;
			if (pend_v_q) begin
				out_status_q <= STATUS_OK;
				out_c_q      <= pend_c_q;
				out_e_q      <= pend_e_q;
				out_last_q   <= 1'b0;
			end
		end
		if (fin) begin
			out_status_q <= STATUS_OK;
			out_c_q      <= pend_v_q ? pend_c_q : '0;
			out_e_q      <= pend_v_q ? pend_e_q : '0;
			out_last_q   <= 1'b1;
		end
		if (err) begin
			out_status_q <= err_order_q ? STATUS_ORDER : STATUS_CAPACITY;
			out_c_q      <= '0;
			out_e_q      <= '0;
			out_last_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && cmd.close) begin
			err_order_q <= cmd.status == STATUS_ORDER;
		end
	end

endmodule

// ===== hdl/sparse_polynomial_adder.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   func, coefficient, exponent, last_term
// out      output     out_valid / out_ready status, sum_coefficient, sum_exponent, last_result
//
// each term is taken while the queue has room and stored by the back end one term per cycle while it loads
// merge: prime the store reads, then one step per cycle while the output is free, then finish
// the front keeps taking terms of the next pair while the back end merges, until its queue fills
// reset clears all counts and flags; the term stores need no clearing
// a stalled output stops the merge; the result register frees on the cycle it is taken
`include "sparse_polynomial_adder_defines.svh"

module sparse_polynomial_adder
	import spa_pkg::*;
#(
	parameter int MAX_TERMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] coefficient,
	input  logic        [15:0] exponent,
	input  logic               last_term,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [1:0]  status,
	output logic signed [16:0] sum_coefficient,
	output logic        [15:0] sum_exponent,
	output logic               last_result
);

	logic push, q_full, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	spa_front #(
		.MAX_TERMS(MAX_TERMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.coefficient(coefficient),
		.exponent   (exponent),
		.last_term  (last_term),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	spa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop_valid(pop_valid),
		.pop_cmd  (pop_cmd),
		.pop_ready(pop_ready)
	);

	spa_back #(
		.MAX_TERMS(MAX_TERMS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (pop_valid),
		.cmd            (pop_cmd),
		.cmd_ready      (pop_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.sum_coefficient(sum_coefficient),
		.sum_exponent   (sum_exponent),
		.last_result    (last_result)
	);

	`SPA_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid)
	`SPA_ASSERT(a_error_is_final, out_valid && status != STATUS_OK |-> last_result)
	`SPA_ASSERT(a_error_is_zero, out_valid && status != STATUS_OK |-> sum_coefficient == '0)
	`SPA_ASSERT(a_zero_only_final, out_valid && sum_coefficient == '0 |-> last_result)
	`SPA_ASSERT(a_queue_no_overflow, push |-> !q_full)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import spa_pkg::*;

	localparam int MAX_TERMS = 16;
	localparam int CLK_HALF = 2;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int TARGET_TERMS = 170;
	localparam int QUIET_TERMS = 30;

	typedef struct {
		status_t            status;
		logic signed [16:0] coef;
		logic        [15:0] expo;
		logic               last;
	} sum_term_t;

	typedef struct {
		logic               op;
		logic signed [15:0] coef;
		logic        [15:0] expo;
		logic               last;
	} poly_term_t;

	typedef enum {PAIR_CLEAN, PAIR_ORDER, PAIR_CAPACITY, PAIR_BOTH} pair_kind_t;

	class poly_sum_model;
		term_t     stored[2][MAX_TERMS];
		int        count[2];
		bit        closed[2];
		bit        order_bad;
		bit        capacity_bad;
		sum_term_t expected_terms[$];
		int        mismatch_count;
		int        terms_taken;
		int        results_checked;
		int        sums_predicted;
		int        error_sums;

		function void clear_pair();
			count[0] = 0;
			count[1] = 0;
			closed[0] = 1'b0;
			closed[1] = 1'b0;
			order_bad = 1'b0;
			capacity_bad = 1'b0;
		endfunction

		function void push_term(status_t st, logic signed [16:0] c, logic [15:0] e, logic last);
			sum_term_t t;
			t.status = st;
			t.coef = c;
			t.expo = e;
			t.last = last;
			expected_terms.push_back(t);
		endfunction

		function void merge_pair();
			int                 i;
			int                 j;
			int                 n_before;
			logic signed [16:0] c;
			logic        [15:0] e;
			i = 0;
			j = 0;
			n_before = expected_terms.size();
			while (i < count[0] || j < count[1]) begin
				if (j >= count[1] || (i < count[0] && stored[0][i].expo < stored[1][j].expo)) begin
					c = $signed(stored[0][i].coef);
					e = stored[0][i].expo;
					i++;
				end else if (i >= count[0] || stored[1][j].expo < stored[0][i].expo) begin
					c = $signed(stored[1][j].coef);
					e = stored[1][j].expo;
					j++;
				end else begin
					c = $signed(stored[0][i].coef) + $signed(stored[1][j].coef);
					e = stored[0][i].expo;
					i++;
					j++;
				end
				if (c != 0)
					push_term(STATUS_OK, c, e, 1'b0);
			end
			if (expected_terms.size() == n_before)
				push_term(STATUS_OK, '0, '0, 1'b1);
			else
				expected_terms[expected_terms.size() - 1].last = 1'b1;
		endfunction

		function void add_input_term(poly_term_t t);
			term_t entry;
			entry.coef = t.coef;
			entry.expo = t.expo;
			terms_taken++;
			if (!closed[t.op]) begin
				if (count[t.op] < MAX_TERMS) begin
					if (count[t.op] > 0 && t.expo <= stored[t.op][count[t.op] - 1].expo)
						order_bad = 1'b1;
					stored[t.op][count[t.op]] = entry;
					count[t.op]++;
				end else begin
					capacity_bad = 1'b1;
				end
				if (t.last)
					closed[t.op] = 1'b1;
			end
			if (!(closed[0] && closed[1]))
				return;
			sums_predicted++;
			if (order_bad || capacity_bad) begin
				error_sums++;
				push_term(order_bad ? STATUS_ORDER : STATUS_CAPACITY, '0, '0, 1'b1);
			end else begin
				merge_pair();
			end
			clear_pair();
		endfunction

		task report_mismatch(string what);
			if (mismatch_count < 40)
				$display("mismatch at %0t: %s", $time, what);
			mismatch_count++;
		endtask

		task check_sum_term(sum_term_t got);
			sum_term_t want;
			if (expected_terms.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d coef %0d expo %0d",
					got.status, got.coef, got.expo));
				return;
			end
			want = expected_terms.pop_front();
			results_checked++;
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.coef !== want.coef)
				report_mismatch($sformatf("sum_coefficient %0d, expected %0d", got.coef, want.coef));
			if (got.expo !== want.expo)
				report_mismatch($sformatf("sum_exponent %0d, expected %0d", got.expo, want.expo));
			if (got.last !== want.last)
				report_mismatch($sformatf("last_result %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic signed [15:0] coefficient;
	logic        [15:0] exponent;
	logic               last_term;
	logic               out_valid;
	logic               out_ready;
	logic        [1:0]  status;
	logic signed [16:0] sum_coefficient;
	logic        [15:0] sum_exponent;
	logic               last_result;

	poly_sum_model model;
	poly_term_t    stim_terms[$];
	poly_term_t    seen_term;
	sum_term_t     seen_result;
	int            junk_terms;
	int            counted_terms;
	int            in_idle_pct;
	int            out_idle_pct;
	int            idle_cycles;

	sparse_polynomial_adder #(.MAX_TERMS(MAX_TERMS)) DUT (.*);

	always #(CLK_HALF) clk = ~clk;

	function automatic void queue_term(logic op, logic signed [15:0] c, logic [15:0] e,
		logic last, bit junk);
		poly_term_t t;
		t.op = op;
		t.coef = c;
		t.expo = e;
		t.last = last;
		stim_terms.push_back(t);
		if (junk)
			junk_terms++;
		else
			counted_terms++;
	endfunction

	function automatic void build_directed();
		// extremes, second operand closing first
		queue_term(1'b1, 16'sh7fff, 16'd0, 1'b0, 1'b0);
		queue_term(1'b0, 16'sh7fff, 16'd0, 1'b0, 1'b0);
		queue_term(1'b1, 16'sh8000, 16'hffff, 1'b1, 1'b0);
		queue_term(1'b0, 16'sh8000, 16'hffff, 1'b1, 1'b0);
		// zero coefficient and cancellation give an empty sum
		queue_term(1'b0, 16'sd0, 16'd1, 1'b0, 1'b0);
		queue_term(1'b0, 16'sd5, 16'd3, 1'b1, 1'b0);
		queue_term(1'b1, -16'sd5, 16'd3, 1'b1, 1'b0);
		// repeated exponent
		queue_term(1'b0, 16'sd1, 16'd5, 1'b0, 1'b0);
		queue_term(1'b0, 16'sd1, 16'd5, 1'b1, 1'b0);
		queue_term(1'b1, 16'sd1, 16'd0, 1'b1, 1'b0);
		// falling exponent
		queue_term(1'b1, 16'sd7, 16'd9, 1'b0, 1'b0);
		queue_term(1'b1, 16'sd7, 16'd8, 1'b1, 1'b0);
		queue_term(1'b0, 16'sd3, 16'd2, 1'b1, 1'b0);
		// terms for a closed operand are dropped
		queue_term(1'b0, 16'sd2, 16'd2, 1'b1, 1'b0);
		queue_term(1'b0, 16'sd9, 16'd9, 1'b0, 1'b1);
		queue_term(1'b0, 16'sd9, 16'd1, 1'b1, 1'b1);
		queue_term(1'b1, 16'sd3, 16'd4, 1'b1, 1'b0);
	endfunction

	function automatic void build_pair(pair_kind_t kind);
		poly_term_t side[2][$];
		poly_term_t t;
		int         pool[$];
		int         pool_len;
		int         step_max;
		int         e;
		int         s;
		int         k;
		int         n;
		int         pick;
		bit         disjoint;
		pool_len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 32) : $urandom_range(1, 8);
		disjoint = pool_len >= 28;
		step_max = ($urandom_range(0, 1) == 0) ? 3 : 2500;
		e = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40000) : $urandom_range(0, 20);
		while (pool.size() < pool_len && e <= 65535) begin
			pool.push_back(e);
			e += $urandom_range(1, step_max);
		end
		foreach (pool[p]) begin
			pick = disjoint ? p % 2 : $urandom_range(0, 2);
			t.expo = 16'(pool[p]);
			t.last = 1'b0;
			if (pick != 1 && side[0].size() < MAX_TERMS) begin
				t.op = 1'b0;
				t.coef = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom_range(0, 65535));
				side[0].push_back(t);
			end
			if (pick != 0 && side[1].size() < MAX_TERMS) begin
				t.op = 1'b1;
				if (pick == 2 && side[0].size() > 0 && side[0][side[0].size() - 1].expo == pool[p]
					&& $urandom_range(0, 2) == 0)
					t.coef = -side[0][side[0].size() - 1].coef;
				else
					t.coef = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom_range(0, 65535));
				side[1].push_back(t);
			end
		end
		for (s = 0; s < 2; s++) begin
			if (side[s].size() == 0) begin
				t.op = s[0];
				t.coef = 16'($urandom_range(0, 65535));
				t.expo = 16'(pool[0]);
				t.last = 1'b0;
				side[s].push_back(t);
			end
		end
		if (kind == PAIR_CAPACITY || kind == PAIR_BOTH) begin
			s = $urandom_range(0, 1);
			n = MAX_TERMS + $urandom_range(1, 3);
			side[s].delete();
			e = $urandom_range(0, 1000);
			for (k = 0; k < n; k++) begin
				t.op = s[0];
				t.coef = 16'($urandom_range(0, 65535));
				t.expo = 16'(e);
				t.last = 1'b0;
				side[s].push_back(t);
				e += $urandom_range(1, 100);
			end
		end
		if (kind == PAIR_ORDER || kind == PAIR_BOTH) begin
			s = $urandom_range(0, 1);
			if (side[s].size() == 1) begin
				t = side[s][0];
				t.coef = 16'($urandom_range(0, 65535));
				side[s].push_back(t);
			end else begin
				n = (side[s].size() < MAX_TERMS) ? side[s].size() : MAX_TERMS;
				k = $urandom_range(1, n - 1);
				side[s][k].expo = 16'($urandom_range(0, side[s][k - 1].expo));
			end
		end
		side[0][side[0].size() - 1].last = 1'b1;
		side[1][side[1].size() - 1].last = 1'b1;
		while (side[0].size() + side[1].size() > 0) begin
			if (side[0].size() == 0)
				s = 1;
			else if (side[1].size() == 0)
				s = 0;
			else
				s = $urandom_range(0, 1);
			t = side[s].pop_front();
			queue_term(t.op, t.coef, t.expo, t.last, 1'b0);
			for (k = 0; k < 2; k++) begin
				if (side[k].size() == 0 && side[1 - k].size() != 0 && $urandom_range(0, 4) == 0)
					queue_term(k[0], 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), 1'b1);
			end
		end
	endfunction

	function automatic int pick_pace();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	task automatic send_term(int idx);
		poly_term_t t;
		t = stim_terms[idx];
		if (idx % 25 == 0) begin
			in_idle_pct = pick_pace();
			out_idle_pct = pick_pace();
		end
		if (idx >= stim_terms.size() - QUIET_TERMS) begin
			in_idle_pct = 0;
			out_idle_pct = 0;
		end
		if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= t.op;
		coefficient <= t.coef;
		exponent <= t.expo;
		last_term <= t.last;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// observe both channels with pre-edge values
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				seen_term.op = func;
				seen_term.coef = coefficient;
				seen_term.expo = exponent;
				seen_term.last = last_term;
				model.add_input_term(seen_term);
			end
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				seen_result.status = status_t'(status);
				seen_result.coef = sum_coefficient;
				seen_result.expo = sum_exponent;
				seen_result.last = last_result;
				model.check_sum_term(seen_result);
			end
			if ((in_valid === 1'b1 && in_ready === 1'b1)
				|| (out_valid === 1'b1 && out_ready === 1'b1))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int pairs;
		pair_kind_t kind;
		model = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func = 1'b0;
		coefficient = '0;
		exponent = '0;
		last_term = 1'b0;
		idle_cycles = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		build_directed();
		pairs = 0;
		while (counted_terms < TARGET_TERMS) begin
			case (pairs)
				0: kind = PAIR_CAPACITY;
				1: kind = PAIR_BOTH;
				2: kind = PAIR_ORDER;
				default: begin
					case ($urandom_range(0, 9))
						0: kind = PAIR_ORDER;
						1: kind = PAIR_CAPACITY;
						2: kind = PAIR_BOTH;
						default: kind = PAIR_CLEAN;
					endcase
				end
			endcase
			build_pair(kind);
			pairs++;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (stim_terms[i])
			send_term(i);
		in_valid <= 1'b0;
		while (model.expected_terms.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.expected_terms.size() != 0)
			model.report_mismatch("expected result terms left over");
		$display("sent %0d terms (%0d to closed operands) in %0d pairs, %0d with errors",
			model.terms_taken, junk_terms, model.sums_predicted, model.error_sums);
		$display("compared %0d result terms, %0d mismatches",
			model.results_checked, model.mismatch_count);
		if (model.mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
